FILE: sv/shcc_pkg.sv
// ----------------------------------------------------------------------------
// Save header check package
// Shared constants, request and result types, and the bytewise CRC-32 update
// used by the save header checker.
// ----------------------------------------------------------------------------
`default_nettype none

package shcc_pkg;

    // Largest file accepted before the result reports too long.
    localparam int MAX_FILE_BYTES_DEF = 65536;

    // Reflected CRC-32 polynomial, init zero, no final inversion.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // Byte offsets within the header.
    localparam int SIG_END      = 4;
    localparam int VER_END      = 8;
    localparam int CHECK_START  = 8;
    localparam int CHECK_END    = 12;
    localparam int NAME_START   = 'h14;
    localparam int NAME_BYTES   = 16;
    localparam int STATUS_AT    = 'h24;
    localparam int CLASS_AT     = 'h28;
    localparam int LEVEL_AT     = 'h2B;

    // Bits of the status byte.
    localparam int HARDCORE_BIT  = 2;
    localparam int EXPANSION_BIT = 5;

    // Widths of the fixed fields.
    localparam int LEN_W      = 17;
    localparam int NAME_LEN_W = 5;

    // Result status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
    localparam logic [2:0] ST_BAD_SIG     = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_TOO_LONG    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIGNATURE = 2'd0;
    localparam logic [1:0] CFG_VERSION_A = 2'd1;
    localparam logic [1:0] CFG_VERSION_B = 2'd2;
    localparam logic [1:0] CFG_MIN_LEN   = 2'd3;

    // Configuration reset values.
    localparam logic [31:0]      SIGNATURE_RST = 32'd0;
    localparam logic [31:0]      VERSION_A_RST = 32'd87;
    localparam logic [31:0]      VERSION_B_RST = 32'd96;
    localparam logic [LEN_W-1:0] MIN_LEN_RST   = 17'd191;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_req_t;

    typedef struct packed {
        logic [2:0]            status;
        logic                  checksum_ok;
        logic [31:0]           computed_crc;
        logic [31:0]           stored_crc;
        logic [LEN_W-1:0]      file_length;
        logic [7:0]            class_code;
        logic [7:0]            level_code;
        logic                  hardcore_flag;
        logic                  expansion_flag;
        logic [NAME_LEN_W-1:0] name_length;
    } result_t;

    typedef struct packed {
        logic [31:0]      expected_signature;
        logic [31:0]      accepted_version_a;
        logic [31:0]      accepted_version_b;
        logic [LEN_W-1:0] minimum_length;
    } cfg_t;

    // Header state after the current byte has been taken in.
    typedef struct packed {
        logic [31:0]           crc;
        logic [31:0]           signature_word;
        logic [31:0]           version_word;
        logic [31:0]           stored_word;
        logic [7:0]            status_byte;
        logic [7:0]            class_byte;
        logic [7:0]            level_byte;
        logic [NAME_LEN_W-1:0] name_count;
    } scan_snap_t;

    // One byte through the reflected CRC, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/shcc_byte_if.sv
// ----------------------------------------------------------------------------
// Byte request channel
// Valid/ready channel that carries one file byte and its last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface shcc_byte_if
    import shcc_pkg::*;
;
    logic      valid;
    logic      ready;
    byte_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/shcc_result_if.sv
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel that carries one header check result.
// ----------------------------------------------------------------------------
`default_nettype none

interface shcc_result_if
    import shcc_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/shcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the expected signature, the two accepted versions and the minimum
// file length, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module shcc_cfg_regs
    import shcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    // Register writes, data masked to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_signature <= SIGNATURE_RST;
            cfg_reg.accepted_version_a <= VERSION_A_RST;
            cfg_reg.accepted_version_b <= VERSION_B_RST;
            cfg_reg.minimum_length     <= MIN_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIGNATURE: cfg_reg.expected_signature <= cfg_data;
                CFG_VERSION_A: cfg_reg.accepted_version_a <= cfg_data;
                CFG_VERSION_B: cfg_reg.accepted_version_b <= cfg_data;
                CFG_MIN_LEN:   cfg_reg.minimum_length     <= cfg_data[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/shcc_scan.sv
// ----------------------------------------------------------------------------
// Header scanner
// Registers each incoming byte, runs the CRC, counts bytes and captures the
// header words and bytes. Hands the updated state to the result stage on
// the last byte and then starts a new file.
// ----------------------------------------------------------------------------
`default_nettype none

module shcc_scan
    import shcc_pkg::*;
#(
    parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEF,
    parameter int CW             = $clog2(MAX_FILE_BYTES + 2)
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    shcc_byte_if.sink   byte_in,
    input  wire logic   result_free,
    output logic        fire,
    output scan_snap_t  snap,
    output logic [CW-1:0] count
);

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FILE_BYTES);

    logic       s_valid_reg;
    logic [7:0] s_byte_reg;
    logic       s_last_reg;
    logic       advance;

    scan_snap_t     st_reg;
    scan_snap_t     st_next;
    logic           name_ended_reg;
    logic           name_ended_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  pos;
    logic [31:0]    byte_shifted;
    logic           in_name;

    // The byte leaves the input register unless it closes a file and the
    // result register is still occupied.
    assign advance       = s_valid_reg && (!s_last_reg || result_free);
    assign byte_in.ready = !s_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (byte_in.valid && byte_in.ready)
        begin
            s_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s_byte_reg <= byte_in.payload.byte_value;
            s_last_reg <= byte_in.payload.last_byte;
        end
    end

    // State after the current byte.
    assign pos          = count_reg;
    assign byte_shifted = {24'd0, s_byte_reg} << {pos[1:0], 3'b000};
    assign in_name      = (pos >= CW'(NAME_START)) && (pos < CW'(NAME_START + NAME_BYTES));

    always_comb
    begin
        st_next         = st_reg;
        name_ended_next = name_ended_reg;
        count_next      = count_reg;

        if (pos < CW'(SIG_END))
        begin
            st_next.signature_word = st_reg.signature_word | byte_shifted;
        end
        else if (pos < CW'(VER_END))
        begin
            st_next.version_word = st_reg.version_word | byte_shifted;
        end
        else if (pos < CW'(CHECK_END))
        begin
            st_next.stored_word = st_reg.stored_word | byte_shifted;
        end

        // The stored checksum bytes are left out of the CRC.
        if ((pos < CW'(CHECK_START)) || (pos >= CW'(CHECK_END)))
        begin
            st_next.crc = crc_byte(st_reg.crc, s_byte_reg);
        end

        // Name length runs up to the first zero byte of the name field.
        if (in_name && !name_ended_reg)
        begin
            if (s_byte_reg == 8'd0)
            begin
                name_ended_next = 1'b1;
            end
            else
            begin
                st_next.name_count = st_reg.name_count + NAME_LEN_W'(1);
            end
        end

        if (pos == CW'(STATUS_AT))
        begin
            st_next.status_byte = s_byte_reg;
        end
        if (pos == CW'(CLASS_AT))
        begin
            st_next.class_byte = s_byte_reg;
        end
        if (pos == CW'(LEVEL_AT))
        begin
            st_next.level_byte = s_byte_reg;
        end

        // Count saturates one past the largest legal file.
        if (count_reg <= MAX_CNT)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // File state, cleared after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            name_ended_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (advance)
        begin
            if (s_last_reg)
            begin
                st_reg         <= '0;
                name_ended_reg <= 1'b0;
                count_reg      <= '0;
            end
            else
            begin
                st_reg         <= st_next;
                name_ended_reg <= name_ended_next;
                count_reg      <= count_next;
            end
        end
    end

    assign fire  = advance && s_last_reg;
    assign snap  = st_next;
    assign count = count_next;

    // A byte held in the input register stays put until it moves on.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && !advance |=> s_valid_reg && $stable(s_byte_reg) && $stable(s_last_reg))
        else $error("stalled input byte changed");

    // The byte counter never passes its saturation point.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT + CW'(1))
        else $error("byte count beyond saturation");

    // The name count never exceeds the name field.
    a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.name_count <= NAME_LEN_W'(NAME_BYTES))
        else $error("name count beyond name field");

endmodule

`default_nettype wire

FILE: sv/shcc_result.sv
// ----------------------------------------------------------------------------
// Result stage
// Judges the finished header against the configuration and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module shcc_result
    import shcc_pkg::*;
#(
    parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEF,
    parameter int CW             = $clog2(MAX_FILE_BYTES + 2)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          fire,
    input  wire scan_snap_t    snap,
    input  wire logic [CW-1:0] count,
    output logic               result_free,
    shcc_result_if.source      result_out
);

    localparam int WW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [WW-1:0] MAX_W   = WW'(MAX_FILE_BYTES);
    localparam logic [WW-1:0] LEN_TOP = WW'((1 << LEN_W) - 1);

    logic          out_valid_reg;
    result_t       res_reg;
    result_t       res_next;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] len_clip;
    logic [2:0]    status;

    assign cnt_w       = WW'(count);
    assign result_free = !out_valid_reg || result_out.ready;

    // Checks in priority order: too long, too small, signature, version.
    always_comb
    begin
        if (cnt_w > MAX_W)
        begin
            status = ST_TOO_LONG;
        end
        else if (cnt_w < WW'(cfg.minimum_length))
        begin
            status = ST_TOO_SMALL;
        end
        else if (snap.signature_word != cfg.expected_signature)
        begin
            status = ST_BAD_SIG;
        end
        else if ((snap.version_word != cfg.accepted_version_a) &&
                 (snap.version_word != cfg.accepted_version_b))
        begin
            status = ST_BAD_VERSION;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Reported length is clipped to the file limit and to the field width.
    always_comb
    begin
        len_clip = (cnt_w > MAX_W) ? MAX_W : cnt_w;
        if (len_clip > LEN_TOP)
        begin
            len_clip = LEN_TOP;
        end
    end

    always_comb
    begin
        res_next.status         = status;
        res_next.checksum_ok    = (status == ST_OK) && (cnt_w >= WW'(CHECK_END)) &&
                                  (snap.crc == snap.stored_word);
        res_next.computed_crc   = snap.crc;
        res_next.stored_crc     = snap.stored_word;
        res_next.file_length    = len_clip[LEN_W-1:0];
        res_next.class_code     = snap.class_byte;
        res_next.level_code     = snap.level_byte;
        res_next.hardcore_flag  = snap.status_byte[HARDCORE_BIT];
        res_next.expansion_flag = snap.status_byte[EXPANSION_BIT];
        res_next.name_length    = snap.name_count;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = res_reg;

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire && out_valid_reg |-> result_out.ready)
        else $error("result overwritten before it was taken");

    // A checksum match is only reported for an accepted file.
    a_ok_needs_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.checksum_ok |-> res_reg.status == ST_OK)
        else $error("checksum_ok with failing status");

    // Every result covers at least one byte.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.file_length != '0)
        else $error("result with zero length");

endmodule

`default_nettype wire

FILE: sv/save_header_check_crc32_unit.sv
// ----------------------------------------------------------------------------
// Save header checker with CRC-32
// Top level: configuration registers, byte scanner and result stage.
// ----------------------------------------------------------------------------
// The unit takes a save file one byte per clock on byte_in, with last_byte set
// on the final byte, and returns one result on result_out per file. Every byte
// passes through an input register and updates the CRC, byte count and
// captured header fields as it leaves it, so a new byte is accepted on every
// clock unless the input stalls. The result is built from the state after the
// last byte and lands in the output register on the same clock edge at which
// that byte leaves the input register; the next file may start at once. Input
// stalls only when a last byte finds the output register still holding an
// untaken result. Configuration writes take effect on the clock edge of cfg_we
// and should be made between files.
// ----------------------------------------------------------------------------
`default_nettype none

module save_header_check_crc32_unit
    import shcc_pkg::*;
#(
    parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    shcc_byte_if.sink        byte_in,
    shcc_result_if.source    result_out
);

    localparam int CW = $clog2(MAX_FILE_BYTES + 2);

    cfg_t          cfg;
    scan_snap_t    snap;
    logic [CW-1:0] count;
    logic          fire;
    logic          result_free;

    // Configuration registers.
    shcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Byte scanner.
    shcc_scan #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES),
        .CW             (CW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (byte_in),
        .result_free (result_free),
        .fire        (fire),
        .snap        (snap),
        .count       (count)
    );

    // Result judgment and output register.
    shcc_result #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES),
        .CW             (CW)
    ) u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (fire),
        .snap        (snap),
        .count       (count),
        .result_free (result_free),
        .result_out  (result_out)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Save header checker testbench
// Streams save files through the checker one byte per request, with random
// source gaps and sink stalls, and compares every result field by field with
// a cycle-free predictor of the header scan and CRC-32. A short directed table
// comes first, then phases of random files under several register settings,
// and at the end one short file against the largest minimum length.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import shcc_pkg::*;

    localparam int FILE_CAP   = MAX_FILE_BYTES_DEF;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 16;

    // Shapes of generated files.
    typedef enum int
    {
        FILE_GOOD,
        FILE_NOISE,
        FILE_BAD_SIG,
        FILE_BAD_VER,
        FILE_BAD_CRC
    } file_kind_t;

    // One row of the directed table; typed rows carry their expected result.
    typedef struct {
        logic [7:0]       value;
        logic             last;
        bit               typed;
        logic [2:0]       status;
        logic [LEN_W-1:0] length;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    shcc_byte_if   byte_ch ();
    shcc_result_if result_ch ();

    save_header_check_crc32_unit #(
        .MAX_FILE_BYTES (FILE_CAP)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    // Mirror of the configuration registers.
    logic [31:0]      want_sig;
    logic [31:0]      want_ver_a;
    logic [31:0]      want_ver_b;
    logic [LEN_W-1:0] want_min_len;

    // Predicted scan state of the file in progress.
    logic [31:0]           scan_crc;
    int                    scan_count;
    logic [31:0]           sig_acc;
    logic [31:0]           ver_acc;
    logic [31:0]           stored_acc;
    logic [7:0]            status_acc;
    logic [7:0]            class_acc;
    logic [7:0]            level_acc;
    logic [NAME_LEN_W-1:0] name_len_acc;
    bit                    name_done;

    result_t    pending_results[$];
    dir_row_t   dir_rows[$];
    logic [7:0] file_buf[];
    int         idle_limit;
    int         bytes_sent;
    int         mismatch_count;
    int         cycle_count;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("save_header_check_crc32_unit regression: fail");
            $finish;
        end
    end

    // Reflected CRC-32 of one byte, one bit at a time from the LSB.
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Start of a new file: every captured field reads as zero.
    function automatic void clear_scan();
        scan_crc     = '0;
        scan_count   = 0;
        sig_acc      = '0;
        ver_acc      = '0;
        stored_acc   = '0;
        status_acc   = '0;
        class_acc    = '0;
        level_acc    = '0;
        name_len_acc = '0;
        name_done    = 1'b0;
    endfunction

    // Takes one byte into the predicted scan; returns 1 with the result on the
    // last byte of a file.
    function automatic bit scan_byte(input byte_req_t req, output result_t res);
        int         pos;
        logic [7:0] b;
        logic [2:0] st;
        pos = scan_count;
        b   = req.byte_value;
        res = '0;

        // Header words, little-endian.
        if (pos < SIG_END)
        begin
            sig_acc[8*pos +: 8] = b;
        end
        else if (pos < VER_END)
        begin
            ver_acc[8*(pos-SIG_END) +: 8] = b;
        end
        else if (pos < CHECK_END)
        begin
            stored_acc[8*(pos-CHECK_START) +: 8] = b;
        end

        // The stored checksum itself is left out of the CRC.
        if (pos < CHECK_START || pos >= CHECK_END)
        begin
            scan_crc = crc32_step(scan_crc, b);
        end

        // Name runs until its first zero byte.
        if (pos >= NAME_START && pos < NAME_START + NAME_BYTES && !name_done)
        begin
            if (b == 8'd0)
            begin
                name_done = 1'b1;
            end
            else
            begin
                name_len_acc = name_len_acc + 1'b1;
            end
        end

        if (pos == STATUS_AT)
        begin
            status_acc = b;
        end
        if (pos == CLASS_AT)
        begin
            class_acc = b;
        end
        if (pos == LEVEL_AT)
        begin
            level_acc = b;
        end

        // The count stops one past the limit.
        if (scan_count <= FILE_CAP)
        begin
            scan_count++;
        end

        if (!req.last_byte)
        begin
            return 1'b0;
        end

        // Checks in priority order.
        if (scan_count > FILE_CAP)
        begin
            st = ST_TOO_LONG;
        end
        else if (scan_count < int'(want_min_len))
        begin
            st = ST_TOO_SMALL;
        end
        else if (sig_acc != want_sig)
        begin
            st = ST_BAD_SIG;
        end
        else if (ver_acc != want_ver_a && ver_acc != want_ver_b)
        begin
            st = ST_BAD_VERSION;
        end
        else
        begin
            st = ST_OK;
        end

        res.status         = st;
        res.checksum_ok    = (st == ST_OK) && (scan_count >= CHECK_END)
                             && (scan_crc == stored_acc);
        res.computed_crc   = scan_crc;
        res.stored_crc     = stored_acc;
        res.file_length    = LEN_W'((scan_count > FILE_CAP) ? FILE_CAP : scan_count);
        res.class_code     = class_acc;
        res.level_code     = level_acc;
        res.hardcore_flag  = status_acc[HARDCORE_BIT];
        res.expansion_flag = status_acc[EXPANSION_BIT];
        res.name_length    = name_len_acc;
        clear_scan();
        return 1'b1;
    endfunction

    // Drives one byte request after a random gap; called at a falling edge and
    // returns at the falling edge after acceptance, valid still high.
    task automatic send_byte(input logic [7:0] value, input logic last,
                             input bit use_typed, input result_t typed_res);
        int      gap;
        result_t res;
        gap = (idle_limit == 0) ? 0 : $urandom_range(idle_limit, 0);
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.payload <= '{byte_value: value, last_byte: last};
        do
        begin
            @(posedge clk);
        end
        while (byte_ch.ready !== 1'b1);
        if (scan_byte('{byte_value: value, last_byte: last}, res))
        begin
            pending_results.push_back(use_typed ? typed_res : res);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
        begin
            send_byte(file_buf[i], i == file_buf.size() - 1, 1'b0, '0);
        end
    endtask

    // Fills file_buf with a file of the given shape under the current setting.
    task automatic build_file(input int len, input file_kind_t kind);
        logic [31:0] ver;
        logic [31:0] crc;
        int          at;
        file_buf = new[len];
        foreach (file_buf[i])
        begin
            file_buf[i] = 8'($urandom_range(255, 0));
        end
        if (kind != FILE_NOISE)
        begin
            ver = $urandom_range(1, 0) ? want_ver_a : want_ver_b;
            if (kind == FILE_BAD_VER)
            begin
                ver = $urandom();
            end
            for (int k = 0; k < 4; k++)
            begin
                if (k < len)
                begin
                    file_buf[k] = want_sig[8*k +: 8];
                end
                if (SIG_END + k < len)
                begin
                    file_buf[SIG_END + k] = ver[8*k +: 8];
                end
            end
            if (kind == FILE_BAD_SIG)
            begin
                at = $urandom_range(SIG_END - 1, 0);
                if (at < len)
                begin
                    file_buf[at] = file_buf[at] ^ (8'd1 << $urandom_range(7, 0));
                end
            end

            // Half of the names end early on a zero byte.
            at = NAME_START + $urandom_range(NAME_BYTES - 1, 0);
            if ($urandom_range(1, 0) && at < len)
            begin
                file_buf[at] = 8'd0;
            end

            // Stored checksum over everything but its own four bytes.
            if (len >= CHECK_END)
            begin
                crc = '0;
                foreach (file_buf[i])
                begin
                    if (i < CHECK_START || i >= CHECK_END)
                    begin
                        crc = crc32_step(crc, file_buf[i]);
                    end
                end
                if (kind == FILE_BAD_CRC)
                begin
                    crc = crc ^ (32'd1 << $urandom_range(31, 0));
                end
                for (int k = 0; k < 4; k++)
                begin
                    file_buf[CHECK_START + k] = crc[8*k +: 8];
                end
            end
        end
    endtask

    // Waits until the unit is idle, then writes all four registers.
    task automatic program_regs(input logic [31:0] sig, input logic [31:0] ver_a,
                                input logic [31:0] ver_b, input logic [LEN_W-1:0] min_len);
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIGNATURE;
        cfg_data  <= sig;
        @(negedge clk);
        cfg_index <= CFG_VERSION_A;
        cfg_data  <= ver_a;
        @(negedge clk);
        cfg_index <= CFG_VERSION_B;
        cfg_data  <= ver_b;
        @(negedge clk);
        cfg_index <= CFG_MIN_LEN;
        cfg_data  <= 32'(min_len);
        @(negedge clk);
        cfg_we       <= 1'b0;
        want_sig     = sig;
        want_ver_a   = ver_a;
        want_ver_b   = ver_b;
        want_min_len = min_len;
    endtask

    // Random files until the byte budget of the phase is spent; mostly
    // well-formed, the rest noise or broken in one place.
    task automatic random_files(input int budget);
        int         r;
        int         len;
        file_kind_t kind;
        int         start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            r    = $urandom_range(9, 0);
            len  = int'(want_min_len) + $urandom_range(40, 0);
            kind = FILE_GOOD;
            if (r == 6)
            begin
                kind = FILE_NOISE;
                len  = $urandom_range(60, 1);
            end
            else if (r == 7)
            begin
                kind = FILE_BAD_SIG;
            end
            else if (r == 8)
            begin
                kind = FILE_BAD_VER;
            end
            else if (r == 9)
            begin
                if ($urandom_range(1, 0))
                begin
                    kind = FILE_BAD_CRC;
                end
                else
                begin
                    len = $urandom_range(int'(want_min_len) - 1, 1);
                end
            end
            build_file(len, kind);
            send_file();
        end
    endtask

    // Compares one field and counts a mismatch.
    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
            mismatch_count++;
        end
    endtask

    // Result sink with random stalls; every accepted result is checked
    // against the oldest expectation.
    initial
    begin
        int      stall;
        result_t want;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = (idle_limit == 0) ? 0 : $urandom_range(idle_limit, 0);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (result_ch.valid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $error("result request arrived with no file pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, result_ch.payload.status);
                check_field("checksum_ok", want.checksum_ok, result_ch.payload.checksum_ok);
                check_field("computed_crc", want.computed_crc,
                            result_ch.payload.computed_crc);
                check_field("stored_crc", want.stored_crc, result_ch.payload.stored_crc);
                check_field("file_length", want.file_length, result_ch.payload.file_length);
                check_field("class_code", want.class_code, result_ch.payload.class_code);
                check_field("level_code", want.level_code, result_ch.payload.level_code);
                check_field("hardcore_flag", want.hardcore_flag,
                            result_ch.payload.hardcore_flag);
                check_field("expansion_flag", want.expansion_flag,
                            result_ch.payload.expansion_flag);
                check_field("name_length", want.name_length, result_ch.payload.name_length);
            end
            @(negedge clk);
        end
    end

    // Stimulus.
    initial
    begin
        result_t typed_res;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_SIGNATURE;
        cfg_data        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.payload = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        bytes_sent      = 0;
        idle_limit      = 12;
        want_sig        = SIGNATURE_RST;
        want_ver_a      = VERSION_A_RST;
        want_ver_b      = VERSION_B_RST;
        want_min_len    = MIN_LEN_RST;
        clear_scan();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table under the reset setting. A one-byte zero file and a
        // twelve-byte zero file are too small, with a zero CRC and nothing
        // captured.
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, ST_TOO_SMALL, 17'd1});
        dir_rows.push_back('{8'hFF, 1'b1, 1'b0, ST_OK, 17'd0});
        for (int i = 0; i < 11; i++)
        begin
            dir_rows.push_back('{8'h00, 1'b0, 1'b0, ST_OK, 17'd0});
        end
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, ST_TOO_SMALL, 17'd12});
        for (int i = 0; i < 7; i++)
        begin
            dir_rows.push_back('{8'hFF, 1'b0, 1'b0, ST_OK, 17'd0});
        end
        dir_rows.push_back('{8'hFF, 1'b1, 1'b0, ST_OK, 17'd0});
        foreach (dir_rows[i])
        begin
            typed_res             = '0;
            typed_res.status      = dir_rows[i].status;
            typed_res.file_length = dir_rows[i].length;
            send_byte(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, typed_res);
        end

        // Reset setting with full-size headers.
        random_files(300);

        // Extreme register values, smallest minimum length.
        program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 17'd12);
        random_files(150);
        program_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 17'd12);
        random_files(150);

        // Random settings; two phases run with no idling at all.
        for (int p = 0; p < 7; p++)
        begin
            program_regs($urandom(), $urandom(), $urandom(),
                         LEN_W'($urandom_range(48, CHECK_END)));
            idle_limit = (p == 2 || p == 5) ? 0 : 12;
            random_files(100);
        end

        // Largest minimum length: a short well-formed file is too small.
        program_regs($urandom(), $urandom(), $urandom(), LEN_W'(FILE_CAP));
        idle_limit = 0;
        build_file(20, FILE_GOOD);
        send_file();
        byte_ch.valid <= 1'b0;

        // Drain and report.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("save_header_check_crc32_unit regression: pass");
        end
        else
        begin
            $display("save_header_check_crc32_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
